>>> rtl/e2c_pkg.sv
package e2c_pkg;

    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned OFF_W   = 5;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned SOD_W   = 17;
    localparam int unsigned DOY_W   = 16;

    // 86400 = 675 * 2^7, 3600 = 225 * 2^4, 60 = 15 * 2^2.
    localparam logic [10:0] C_DAY_DIV  = 11'd675;
    localparam logic [8:0]  C_HOUR_DIV = 9'd225;
    localparam logic [8:0]  C_MIN_DIV  = 9'd15;

    localparam logic signed [17:0] C_SEC_PER_HOUR = 18'sd3600;
    localparam logic [32:0]        C_SEC_PER_DAY  = 33'd86400;

    localparam logic [DOY_W-1:0]  C_DOY_BIAS        = 16'd364;
    localparam logic [YEAR_W-1:0] C_BASE_YEAR       = 12'd1969;
    localparam logic [YEAR_W-1:0] C_CENT_YEAR       = 12'd2100;
    localparam logic [YEAR_W-1:0] C_SHORT_BLOCK_YR  = 12'd2097;
    localparam logic [MONTH_W-1:0] C_LAST_MONTH     = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_WORK = 3'b100
    } t_top_state;

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_YEAR  = 4'b0010,
        D_MONTH = 4'b0100,
        D_DONE  = 4'b1000
    } t_date_state;

    typedef enum logic [3:0] {
        K_IDLE = 4'b0001,
        K_HOUR = 4'b0010,
        K_MIN  = 4'b0100,
        K_DONE = 4'b1000
    } t_clk_state;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/epoch_seconds_to_calendar.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian year, month, day, hour, minute and second, after adding a signed
// whole-hour zone offset that carries into the date.
// The input channel takes a word at a clock edge where i_valid is high and
// o_stall is low; the output channel hands over a word where o_valid is high
// and i_stall is low. The offset register is written by i_cfg_we with
// i_cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce this. It reads 2 after reset.
// One word is converted at a time. The day count comes from a bit-serial
// division by 675. The date is then found by taking off four-year blocks and
// single years, then months, one step a cycle; the time of day runs alongside
// it in two serial divisions. A new word is taken in the cycle after the
// result is loaded into the output register. o_stall stays high for the whole
// conversion. A stalled result holds in the output register while the next
// word is accepted and converted; that word then waits, with o_stall high,
// until the output register is free.
// Reset is synchronous and active low: it drops any word in flight, clears
// o_valid and sets the offset back to 2.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [EPOCH_W-1:0] i_epoch_seconds,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [YEAR_W-1:0]  o_year_out,
    output logic [MONTH_W-1:0] o_month_out,
    output logic [DAY_W-1:0]   o_day_out,
    output logic [HOUR_W-1:0]  o_hour_out,
    output logic [MIN_W-1:0]   o_minute_out,
    output logic [SEC_W-1:0]   o_second_out,
    input  logic               i_cfg_we,
    input  logic [OFF_W-1:0]   i_cfg_wdata
);

    t_top_state        r_state;
    logic [OFF_W-1:0]  r_off;
    logic [4:0]        r_cnt;
    logic [25:0]       r_dvd;
    logic [9:0]        r_rem;
    logic [6:0]        r_lo;
    logic              r_start;
    logic              r_o_valid;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_minute;
    logic [SEC_W-1:0]   r_second;

    logic               n_accept;
    logic signed [17:0] n_off_sec;
    logic [32:0]        n_t;
    logic [10:0]        n_part;
    logic               n_ge;
    logic [9:0]         n_rem;
    logic               n_out_free;
    logic               n_load;

    logic               d_done;
    logic [YEAR_W-1:0]  d_year;
    logic [MONTH_W-1:0] d_month;
    logic [DAY_W-1:0]   d_day;
    logic               k_done;
    logic [HOUR_W-1:0]  k_hour;
    logic [MIN_W-1:0]   k_minute;
    logic [SEC_W-1:0]   k_second;

    always_comb begin
        n_accept   = i_valid && !o_stall;
        n_off_sec  = 18'(signed'(r_off)) * C_SEC_PER_HOUR;
        n_t        = 33'(i_epoch_seconds) + {{15{n_off_sec[17]}}, n_off_sec} + C_SEC_PER_DAY;
        n_part     = {r_rem, r_dvd[25]};
        n_ge       = (n_part >= C_DAY_DIV);
        n_rem      = n_ge ? 10'(n_part - C_DAY_DIV) : n_part[9:0];
        n_out_free = !r_o_valid || !i_stall;
        n_load     = (r_state == S_WORK) && !r_start && d_done && k_done && n_out_free;
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= 5'd2;
        end else if (i_cfg_we) begin
            r_off <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: if (n_accept) r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_state <= S_WORK;
                        r_start <= 1'b1;
                    end
                end
                S_WORK:  if (n_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (n_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_dvd <= n_t[32:7];
            r_lo  <= n_t[6:0];
            r_rem <= '0;
            r_cnt <= 5'd25;
        end else if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[24:0], n_ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_year   <= d_year;
            r_month  <= d_month;
            r_day    <= d_day;
            r_hour   <= k_hour;
            r_minute <= k_minute;
            r_second <= k_second;
        end
    end

    e2c_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_doy   (r_dvd[DOY_W-1:0] + C_DOY_BIAS),
        .o_done  (d_done),
        .o_year  (d_year),
        .o_month (d_month),
        .o_day   (d_day)
    );

    e2c_clock u_clock (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_sod    ({r_rem, r_lo}),
        .o_done   (k_done),
        .o_hour   (k_hour),
        .o_minute (k_minute),
        .o_second (k_second)
    );

    assign o_valid      = r_o_valid;
    assign o_year_out   = r_year;
    assign o_month_out  = r_month;
    assign o_day_out    = r_day;
    assign o_hour_out   = r_hour;
    assign o_minute_out = r_minute;
    assign o_second_out = r_second;

endmodule

>>> rtl/e2c_date.sv
module e2c_date
    import e2c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DOY_W-1:0]   i_doy,
    output logic               o_done,
    output logic [YEAR_W-1:0]  o_year,
    output logic [MONTH_W-1:0] o_month,
    output logic [DAY_W-1:0]   o_day
);

    t_date_state        r_state;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DOY_W-1:0]   r_doy;

    logic             n_leap;
    logic [DOY_W-1:0] n_ylen;
    logic [DOY_W-1:0] n_blen;
    logic             n_blk_ok;
    logic [DOY_W-1:0] n_mlen;

    always_comb begin
        n_leap   = (r_year[1:0] == 2'b00) && (r_year != C_CENT_YEAR);
        n_ylen   = n_leap ? 16'd366 : 16'd365;
        n_blen   = (r_year == C_SHORT_BLOCK_YR) ? 16'd1460 : 16'd1461;
        n_blk_ok = (r_year[1:0] == 2'b01) && (r_doy >= n_blen);
        n_mlen   = DOY_W'(month_len(r_month, n_leap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else if (i_start) begin
            r_state <= D_YEAR;
        end else begin
            unique case (r_state)
                D_YEAR: begin
                    if (!n_blk_ok && r_doy < n_ylen) begin
                        r_state <= D_MONTH;
                    end
                end
                D_MONTH: begin
                    if (r_doy < n_mlen || r_month >= C_LAST_MONTH) begin
                        r_state <= D_DONE;
                    end
                end
                default: r_state <= r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_year  <= C_BASE_YEAR;
            r_month <= '0;
            r_doy   <= i_doy;
        end else if (r_state == D_YEAR) begin
            if (n_blk_ok) begin
                r_doy  <= r_doy - n_blen;
                r_year <= r_year + 12'd4;
            end else if (r_doy >= n_ylen) begin
                r_doy  <= r_doy - n_ylen;
                r_year <= r_year + 12'd1;
            end
        end else if (r_state == D_MONTH) begin
            if (!(r_doy < n_mlen || r_month >= C_LAST_MONTH)) begin
                r_doy   <= r_doy - n_mlen;
                r_month <= r_month + 4'd1;
            end
        end
    end

    assign o_done  = (r_state == D_DONE);
    assign o_year  = r_year;
    assign o_month = r_month + 4'd1;
    assign o_day   = r_doy[DAY_W-1:0] + 5'd1;

endmodule

>>> rtl/e2c_clock.sv
module e2c_clock
    import e2c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SOD_W-1:0]  i_sod,
    output logic              o_done,
    output logic [HOUR_W-1:0] o_hour,
    output logic [MIN_W-1:0]  o_minute,
    output logic [SEC_W-1:0]  o_second
);

    t_clk_state        r_state;
    logic [3:0]        r_cnt;
    logic [12:0]       r_dvd;
    logic [7:0]        r_rem;
    logic [3:0]        r_lo;
    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_minute;
    logic [SEC_W-1:0]  r_second;

    logic [8:0]  n_part;
    logic [8:0]  n_div;
    logic        n_ge;
    logic [7:0]  n_rem;
    logic [12:0] n_dvd;

    // One quotient bit per cycle, restoring division on a narrow remainder.
    always_comb begin
        n_div  = (r_state == K_HOUR) ? C_HOUR_DIV : C_MIN_DIV;
        n_part = {r_rem, r_dvd[12]};
        n_ge   = (n_part >= n_div);
        n_rem  = n_ge ? 8'(n_part - n_div) : n_part[7:0];
        n_dvd  = {r_dvd[11:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
        end else if (i_start) begin
            r_state <= K_HOUR;
        end else begin
            unique case (r_state)
                K_HOUR:  if (r_cnt == 4'd0) r_state <= K_MIN;
                K_MIN:   if (r_cnt == 4'd0) r_state <= K_DONE;
                default: r_state <= r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_sod[16:4];
            r_lo  <= i_sod[3:0];
            r_rem <= '0;
            r_cnt <= 4'd12;
        end else if (r_state == K_HOUR) begin
            if (r_cnt == 4'd0) begin
                r_hour <= n_dvd[HOUR_W-1:0];
                r_dvd  <= {3'b000, n_rem, r_lo[3:2]};
                r_lo   <= {2'b00, r_lo[1:0]};
                r_rem  <= '0;
                r_cnt  <= 4'd12;
            end else begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 4'd1;
            end
        end else if (r_state == K_MIN) begin
            if (r_cnt == 4'd0) begin
                r_minute <= n_dvd[MIN_W-1:0];
                r_second <= {n_rem[3:0], r_lo[1:0]};
            end else begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    assign o_done   = (r_state == K_DONE);
    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import e2c_pkg::*;

    localparam longint SECS_PER_DAY   = 86400;
    localparam longint SECS_PER_HOUR  = 3600;
    localparam int     LONG_HOLD      = 400;
    localparam int     WATCHDOG_LIMIT = 6000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_pace;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_calendar;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [EPOCH_W-1:0] i_epoch_seconds = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [YEAR_W-1:0]  o_year_out;
    logic [MONTH_W-1:0] o_month_out;
    logic [DAY_W-1:0]   o_day_out;
    logic [HOUR_W-1:0]  o_hour_out;
    logic [MIN_W-1:0]   o_minute_out;
    logic [SEC_W-1:0]   o_second_out;
    logic               i_cfg_we = 1'b0;
    logic [OFF_W-1:0]   i_cfg_wdata = '0;

    logic [EPOCH_W-1:0] pending_epochs [$];
    t_calendar          expected_dates [$];
    logic signed [OFF_W-1:0] zone_offset = 5'sd2;
    t_pace              pace = IDLE_NONE;
    bit                 sender_hold = 1'b0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_year_out      (o_year_out),
        .o_month_out     (o_month_out),
        .o_day_out       (o_day_out),
        .o_hour_out      (o_hour_out),
        .o_minute_out    (o_minute_out),
        .o_second_out    (o_second_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_calendar gregorian_from_epoch(logic [EPOCH_W-1:0] secs,
                                                       logic signed [OFF_W-1:0] zone);
        longint      shifted;
        longint      day_of_year;
        longint      sec_of_day;
        int unsigned year;
        int unsigned month;
        int unsigned span;
        bit          leap;
        bit          done;
        t_calendar   cal;
        // The extra day keeps the sum positive; day 0 is then 1969-12-31.
        shifted = longint'(secs) + longint'(zone) * SECS_PER_HOUR + SECS_PER_DAY;
        sec_of_day = shifted % SECS_PER_DAY;
        day_of_year = shifted / SECS_PER_DAY + 364;
        year = 1969;
        leap = 1'b0;
        done = 1'b0;
        while (!done) begin
            leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
            span = leap ? 366 : 365;
            if (day_of_year < span) begin
                done = 1'b1;
            end else begin
                day_of_year -= span;
                year++;
            end
        end
        month = 0;
        done = 1'b0;
        while (!done) begin
            case (month)
                1: begin
                    span = leap ? 29 : 28;
                end
                3, 5, 8, 10: begin
                    span = 30;
                end
                default: begin
                    span = 31;
                end
            endcase
            if (day_of_year < span || month >= 11) begin
                done = 1'b1;
            end else begin
                day_of_year -= span;
                month++;
            end
        end
        cal.year   = YEAR_W'(year);
        cal.month  = MONTH_W'(month + 1);
        cal.day    = DAY_W'(day_of_year + 1);
        cal.hour   = HOUR_W'(sec_of_day / SECS_PER_HOUR);
        cal.minute = MIN_W'((sec_of_day / 60) % 60);
        cal.second = SEC_W'(sec_of_day % 60);
        return cal;
    endfunction

    function automatic bit takes_break(bit receiver_side);
        int unsigned chance;
        chance = 0;
        if (pace == IDLE_BOTH) begin
            chance = 7;
        end else if ((pace == IDLE_SENDER && !receiver_side) ||
                     (pace == IDLE_RECEIVER && receiver_side)) begin
            chance = 45;
        end
        return $urandom_range(0, 99) < chance;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : sender
        bit busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                expected_dates.push_back(gregorian_from_epoch(i_epoch_seconds, zone_offset));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_epochs.size() != 0 && !sender_hold && !takes_break(1'b0)) begin
                    i_valid <= 1'b1;
                    i_epoch_seconds <= pending_epochs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        t_calendar want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("Output word arrived with no date expected.");
                    mismatch_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("year_out", want.year, o_year_out);
                    check_field("month_out", want.month, o_month_out);
                    check_field("day_out", want.day, o_day_out);
                    check_field("hour_out", want.hour, o_hour_out);
                    check_field("minute_out", want.minute, o_minute_out);
                    check_field("second_out", want.second, o_second_out);
                end
            end
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left <= LONG_HOLD;
                i_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= takes_break(1'b1);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (pending_epochs.size() == 0 && !i_valid && expected_dates.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("epoch_seconds_to_calendar verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        @(negedge i_clk);
        while (pending_epochs.size() != 0 || i_valid || expected_dates.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_zone(logic [OFF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        zone_offset = value;
        @(negedge i_clk);
    endtask

    task automatic add_random(int unsigned count);
        logic [EPOCH_W-1:0] word;
        int unsigned        day;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: begin
                    word = $urandom();
                end
                1: begin
                    word = $urandom_range(0, 200000);
                end
                2: begin
                    word = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                end
                default: begin
                    // Land within two hours of a midnight so the offset moves the date.
                    day = $urandom_range(1, 49709);
                    word = day * 32'd86400 + $urandom_range(0, 14400) - 32'd7200;
                end
            endcase
            pending_epochs.push_back(word);
        end
    endtask

    initial begin : stimulus
        t_pace pace_plan [4];
        pace_plan = '{IDLE_BOTH, IDLE_SENDER, IDLE_NONE, IDLE_RECEIVER};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The offset still holds its reset value here.
        pace = IDLE_NONE;
        pending_epochs.push_back(32'd0);
        pending_epochs.push_back(32'd1);
        pending_epochs.push_back(32'd3599);
        pending_epochs.push_back(32'd86399);
        pending_epochs.push_back(32'd31535999);
        pending_epochs.push_back(32'd68169599);
        pending_epochs.push_back(32'd951782400);
        pending_epochs.push_back(32'd4107542399);
        pending_epochs.push_back(32'd4107542400);
        pending_epochs.push_back(32'h7FFF_FFFF);
        pending_epochs.push_back(32'h8000_0000);
        pending_epochs.push_back(32'hFFFF_FFFF);
        add_random(40);
        drain();

        hold_requests = hold_requests + 1;
        add_random(40);
        drain();

        add_random(40);
        while (pending_epochs.size() > 20) @(negedge i_clk);
        sender_hold = 1'b1;
        while (i_valid || expected_dates.size() != 0) @(negedge i_clk);
        sender_hold = 1'b0;
        drain();

        set_zone(OFF_W'(-16));
        pace = IDLE_SENDER;
        pending_epochs.push_back(32'd0);
        pending_epochs.push_back(32'd3599);
        pending_epochs.push_back(32'd57599);
        pending_epochs.push_back(32'd57600);
        add_random(70);
        drain();

        set_zone(OFF_W'(15));
        pace = IDLE_RECEIVER;
        pending_epochs.push_back(32'hFFFF_FFFF);
        pending_epochs.push_back(32'hFFFF_FFFF - 32'd3600);
        add_random(70);
        drain();

        set_zone(OFF_W'(14));
        pace = IDLE_BOTH;
        pending_epochs.push_back(32'hFFFF_FFFF);
        add_random(70);
        drain();

        set_zone(OFF_W'(-12));
        pace = IDLE_NONE;
        pending_epochs.push_back(32'd0);
        add_random(70);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_zone(OFF_W'($urandom_range(0, 31)));
            pace = pace_plan[p];
            add_random(70);
            drain();
        end

        set_zone(OFF_W'(0));
        pace = IDLE_BOTH;
        add_random(70);
        drain();

        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("epoch_seconds_to_calendar verification clean");
        end else begin
            $display("epoch_seconds_to_calendar verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/e2c_pkg.sv
rtl/e2c_date.sv
rtl/e2c_clock.sv
rtl/epoch_seconds_to_calendar.sv
tb/testbench.sv
